@@ rtl/pfr_pkg.sv @@
// Shared types and constants of the page frame replacement unit.
`default_nettype none

package pfr_pkg;

	// Field widths
	localparam int PAGE_W    = 19;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 32;
	localparam int FRAME_W   = 9;
	localparam int ADDR_W    = 32;

	// Built depth of the frame table
	localparam int DEF_MAX_FRAMES = 512;

	// Configuration register widths and port shape
	localparam int CFG_POLICY_W = 1;
	localparam int CFG_PSIZE_W  = 5;
	localparam int CFG_FRAMES_W = 10;
	localparam int CFG_AGE_W    = 8;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_INDEX_W  = 2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POLICY    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAGE_SIZE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAMES    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_AGE_LIMIT = 2'd3;

	// Register reset values
	localparam logic [CFG_POLICY_W-1:0] RST_POLICY    = 1'b0;
	localparam logic [CFG_PSIZE_W-1:0]  RST_PAGE_SIZE = 5'd8;
	localparam logic [CFG_FRAMES_W-1:0] RST_FRAMES    = 10'd128;
	localparam logic [CFG_AGE_W-1:0]    RST_AGE_LIMIT = 8'd5;

	// Policy codes
	localparam logic [CFG_POLICY_W-1:0] POLICY_LRU = 1'b0;
	localparam logic [CFG_POLICY_W-1:0] POLICY_NRU = 1'b1;

	// Page size at and above which the shift is 14 instead of 13
	localparam logic [CFG_PSIZE_W-1:0] PSIZE_BIG = 5'd16;

	// One frame table entry
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] stamp;
		logic              referenced;
		logic              dirty;
	} entry_t;

	localparam int ENTRY_W = PAGE_W + TIME_W + 2;

	// Control of the lookup and victim scan
	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

endpackage

`default_nettype wire

@@ rtl/pfr_scan.sv @@
// Lookup and victim tracker fed one frame table entry per cycle while valid is set.
`default_nettype none

module pfr_scan #(
	parameter int IDX_W = 9
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pfr_pkg::scan_ctl_t          ctl,
	input  wire logic                        policy,
	input  wire logic [pfr_pkg::PAGE_W-1:0]  page,
	input  wire pfr_pkg::entry_t             entry,
	input  wire logic [IDX_W-1:0]            idx,
	output logic                             found,
	output logic [IDX_W-1:0]                 match_idx,
	output logic [IDX_W-1:0]                 victim_idx
);

	import pfr_pkg::*;

	logic              found_q;
	logic              have_q;
	logic [IDX_W-1:0]  match_q;
	logic [IDX_W-1:0]  best_q;
	logic [TIME_W-1:0] best_key_q;
	logic [TIME_W-1:0] key;
	logic              is_match;
	logic              is_better;

	// Rank by class for NRU, by stamp for LRU
	always_comb begin
		if (policy == POLICY_NRU) begin
			key = TIME_W'({entry.referenced, entry.dirty});
		end else begin
			key = entry.stamp;
		end
		is_match  = !found_q && (entry.page == page);
		is_better = !have_q || (key < best_key_q);
	end

	// Track the first match and the first lowest-ranked frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
			have_q  <= 1'b0;
		end else if (ctl.valid) begin
			if (is_match) begin
				found_q <= 1'b1;
			end
			if (is_better) begin
				have_q <= 1'b1;
			end
		end
	end

	// Hold indexes and the best key
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.clear) begin
			if (is_match) begin
				match_q <= idx;
			end
			if (is_better) begin
				best_q     <= idx;
				best_key_q <= key;
			end
		end
	end

	assign found      = found_q;
	assign match_idx  = match_q;
	assign victim_idx = best_q;

endmodule

`default_nettype wire

@@ rtl/page_frame_replacement_lru_nru.sv @@
// Top level of the page frame replacement unit with LRU and NRU policies.
//
// Channel  Dir  Carries
// s_*      in   access: tdata = address, tuser = is_write
// m_*      out  result: tuser = hit, tdata = frame, fault_total, write_fault_total
// cfg_*    in   register writes: policy, page_size_kb, frames_in_use, age_limit
//
// An access makes a lookup pass and an aging pass over the live frames, the
// filled frames in use (at most 512 at a depth of 512); each pass walks the
// frame table through its single read port, one entry per cycle.
// Reset is asynchronous; the table needs no clearing pass, since only filled
// frames are ever read. A new access is taken while a result waits on m_*;
// the next result waits in its final state until the output register frees.
`default_nettype none

module page_frame_replacement_lru_nru #(
	parameter int MAX_FRAMES = pfr_pkg::DEF_MAX_FRAMES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Access input
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [pfr_pkg::ADDR_W-1:0]        s_tdata,  // [31:0] address
	input  wire logic                              s_tuser,  // [0] is_write
	// Result output
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [8:0] frame, [40:9] fault_total, [72:41] write_fault_total, [79:73] zero
	output logic [79:0]                            m_tdata,
	output logic                                   m_tuser,  // [0] hit
	// Configuration
	input  wire logic                              cfg_wr_en,
	input  wire logic [pfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [pfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import pfr_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W = (CNT_W > CFG_FRAMES_W) ? CNT_W : CFG_FRAMES_W;
	localparam int OUT_W = FRAME_W + 2 * COUNT_W;
	localparam int PAD_W = 80 - OUT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_AGE    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	// Configuration registers
	logic [CFG_POLICY_W-1:0] policy_q;
	logic [CFG_PSIZE_W-1:0]  psize_q;
	logic [CFG_FRAMES_W-1:0] frames_q;
	logic [CFG_AGE_W-1:0]    age_limit_q;

	// Control and counters
	logic [2:0]         state_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   filled_q;
	logic [TIME_W-1:0]  tick_q;
	logic [COUNT_W-1:0] faults_q;
	logic [COUNT_W-1:0] wfaults_q;

	// Current access and its outcome
	logic [PAGE_W-1:0]  page_q;
	logic               wr_q;
	logic               hit_q;
	logic [IDX_W-1:0]   slot_q;

	// Output register
	logic               m_tvalid_q;
	logic               m_hit_q;
	logic [FRAME_W-1:0] m_frame_q;
	logic [COUNT_W-1:0] m_faults_q;
	logic [COUNT_W-1:0] m_wfaults_q;

	// Frame table and its read pipeline
	logic [ENTRY_W-1:0] mem [MAX_FRAMES];
	logic [ENTRY_W-1:0] rd_q;
	logic               rv_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_ra;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	entry_t             mem_wd;
	entry_t             rd_entry;

	// Derived values
	logic [CMP_W-1:0]        cap_ext;
	logic [CMP_W-1:0]        frames_ext;
	logic [CNT_W-1:0]        cap;
	logic [CNT_W-1:0]        live;
	logic                    room;
	logic [PAGE_W-1:0]       page_in;
	logic [IDX_W-1:0]        slot_next;
	logic [TIME_W-1:0]       age;
	logic                    aged;
	logic                    in_xfer;
	logic                    walking;
	logic                    walk_done;
	logic [IDX_W+FRAME_W-1:0] slot_wide;

	// Scan unit
	scan_ctl_t          scan_ctl;
	logic               found;
	logic [IDX_W-1:0]   match_idx;
	logic [IDX_W-1:0]   victim_idx;

	assign rd_entry = entry_t'(rd_q);

	// Clamp the capacity into one through the built depth
	always_comb begin
		frames_ext = CMP_W'(frames_q);
		if (frames_q == '0) begin
			cap_ext = CMP_W'(1);
		end else if (frames_ext > CMP_W'(MAX_FRAMES)) begin
			cap_ext = CMP_W'(MAX_FRAMES);
		end else begin
			cap_ext = frames_ext;
		end
		cap  = cap_ext[CNT_W-1:0];
		room = filled_q < cap;
		live = room ? filled_q : cap;
	end

	// Page number: shift 13 below 16 KB, else 14
	always_comb begin
		if (psize_q < PSIZE_BIG) begin
			page_in = s_tdata[ADDR_W-1:13];
		end else begin
			page_in = {1'b0, s_tdata[ADDR_W-1:14]};
		end
	end

	// Pick the frame for this access
	always_comb begin
		if (found) begin
			slot_next = match_idx;
		end else if (room) begin
			slot_next = filled_q[IDX_W-1:0];
		end else begin
			slot_next = victim_idx;
		end
	end

	// Aging test against the advanced tick
	always_comb begin
		age  = tick_q - rd_entry.stamp;
		aged = age >= TIME_W'(age_limit_q);
	end

	// Walk reads and write-back selection
	always_comb begin
		walking   = (state_q == ST_SCAN) || (state_q == ST_AGE);
		mem_re    = walking && (idx_q < live);
		mem_ra    = idx_q[IDX_W-1:0];
		walk_done = walking && !mem_re && !rv_s1;
		mem_we    = 1'b0;
		mem_wa    = slot_next;
		mem_wd    = '0;
		case (state_q)
			ST_UPDATE: begin
				mem_we            = 1'b1;
				mem_wa            = slot_next;
				mem_wd.page       = page_q;
				mem_wd.stamp      = tick_q;
				mem_wd.referenced = 1'b1;
				mem_wd.dirty      = found ? wr_q : 1'b0;
			end
			ST_AGE: begin
				mem_we            = rv_s1;
				mem_wa            = idx_s1;
				mem_wd            = rd_entry;
				mem_wd.referenced = rd_entry.referenced && !aged;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Frame table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
		idx_s1 <= mem_ra;
	end

	// Track reads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= mem_re;
		end
	end

	assign scan_ctl.clear = (state_q == ST_IDLE);
	assign scan_ctl.valid = rv_s1 && (state_q == ST_SCAN);

	pfr_scan #(
		.IDX_W(IDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.policy     (policy_q),
		.page       (page_q),
		.entry      (rd_entry),
		.idx        (idx_s1),
		.found      (found),
		.match_idx  (match_idx),
		.victim_idx (victim_idx)
	);

	assign in_xfer = s_tvalid && s_tready;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= RST_POLICY;
			psize_q     <= RST_PAGE_SIZE;
			frames_q    <= RST_FRAMES;
			age_limit_q <= RST_AGE_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_POLICY:    policy_q    <= cfg_data[CFG_POLICY_W-1:0];
				REG_PAGE_SIZE: psize_q     <= cfg_data[CFG_PSIZE_W-1:0];
				REG_FRAMES:    frames_q    <= cfg_data[CFG_FRAMES_W-1:0];
				REG_AGE_LIMIT: age_limit_q <= cfg_data[CFG_AGE_W-1:0];
				default:       policy_q    <= policy_q;
			endcase
		end
	end

	// Sequence one access: lookup, update, aging, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			filled_q    <= '0;
			tick_q      <= '0;
			faults_q    <= '0;
			wfaults_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			if (mem_re) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (walk_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (!found) begin
						faults_q <= faults_q + COUNT_W'(1);
						if (wr_q) begin
							wfaults_q <= wfaults_q + COUNT_W'(1);
						end
						if (room) begin
							filled_q <= filled_q + CNT_W'(1);
						end
					end
					tick_q  <= tick_q + TIME_W'(1);
					idx_q   <= '0;
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					if (walk_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign slot_wide = {{FRAME_W{1'b0}}, slot_q};

	// Hold the access and its result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			page_q <= page_in;
			wr_q   <= s_tuser;
		end
		if (state_q == ST_UPDATE) begin
			hit_q  <= found;
			slot_q <= slot_next;
		end
		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_hit_q     <= hit_q;
			m_frame_q   <= slot_wide[FRAME_W-1:0];
			m_faults_q  <= faults_q;
			m_wfaults_q <= wfaults_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_wfaults_q, m_faults_q, m_frame_q};

	// Checks
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_SCAN)
		else $error("accepted access did not start the lookup");

	a_faults_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_UPDATE |=> $stable(faults_q))
		else $error("fault count moved outside the update step");

	a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_wa != mem_ra)
		else $error("read and write hit the same frame table entry");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");

	a_filled_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |=> filled_q <= CNT_W'(MAX_FRAMES))
		else $error("filled count beyond the table depth");

endmodule

`default_nettype wire

@@ verif/page_frame_replacement_lru_nru_tb.sv @@
// Self-checking testbench for the page frame replacement unit (LRU and NRU policies).
module page_frame_replacement_lru_nru_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfr_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int NOISE_PCT = 15;

	typedef struct packed {
		logic                hit;
		logic [FRAME_W-1:0]  frame;
		logic [COUNT_W-1:0]  fault_total;
		logic [COUNT_W-1:0]  write_fault_total;
	} access_outcome_t;

	typedef enum int {RX_STEADY, RX_SPARSE, RX_BURSTY} rx_mode_e;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [ADDR_W-1:0]       s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [79:0]             m_tdata;
	logic                    m_tuser;
	logic                    cfg_wr_en;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Mirror of the frame table and counters
	logic [PAGE_W-1:0]       resident_page [DEF_MAX_FRAMES];
	logic [TIME_W-1:0]       last_use [DEF_MAX_FRAMES];
	bit                      ref_bit [DEF_MAX_FRAMES];
	bit                      dirty_bit [DEF_MAX_FRAMES];
	int unsigned             filled_count;
	logic [TIME_W-1:0]       now_tick;
	logic [COUNT_W-1:0]      fault_count;
	logic [COUNT_W-1:0]      write_fault_count;

	// Mirror of the registers
	logic [CFG_POLICY_W-1:0] cur_policy;
	logic [CFG_PSIZE_W-1:0]  cur_page_kb;
	logic [CFG_FRAMES_W-1:0] cur_frames;
	logic [CFG_AGE_W-1:0]    cur_age;

	access_outcome_t         awaited_outcomes [$];
	logic [PAGE_W-1:0]       page_pool [$];
	int unsigned             mismatches;
	int unsigned             results_seen;
	int unsigned             burst_left;
	int unsigned             quiet_cycles;

	page_frame_replacement_lru_nru dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Derive the address shift from the page size; small sizes clamp to 8 KB
	function automatic int unsigned page_shift(logic [CFG_PSIZE_W-1:0] kb);
		int unsigned sz;
		int unsigned lg;
		sz = (kb < 8) ? 8 : kb;
		lg = 0;
		while (sz > 1) begin
			sz = sz >> 1;
			lg++;
		end
		return lg + 10;
	endfunction

	// Clamp the frame count into 1..depth
	function automatic int unsigned frame_capacity();
		if (cur_frames == 0)
			return 1;
		if (cur_frames > DEF_MAX_FRAMES)
			return DEF_MAX_FRAMES;
		return cur_frames;
	endfunction

	// Advance the mirror by one access and return the result it should produce
	function automatic access_outcome_t predict_access(logic [ADDR_W-1:0] addr, logic wr);
		access_outcome_t r;
		logic [PAGE_W-1:0] page;
		logic [TIME_W-1:0] oldest;
		int unsigned cap;
		int unsigned live;
		int unsigned slot;
		int unsigned best_cls;
		int unsigned cls;
		bit found;
		page = PAGE_W'(addr >> page_shift(cur_page_kb));
		cap = frame_capacity();
		live = (filled_count < cap) ? filled_count : cap;
		found = 1'b0;
		slot = 0;
		// look up among live frames, first match wins
		for (int i = 0; i < live; i++) begin
			if (!found && resident_page[i] == page) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			ref_bit[slot] = 1'b1;
			last_use[slot] = now_tick;
			dirty_bit[slot] = wr;
		end else begin
			fault_count++;
			if (wr)
				write_fault_count++;
			if (filled_count < cap) begin
				slot = filled_count;
				filled_count++;
			end else if (cur_policy == POLICY_NRU) begin
				// lowest class of referenced then dirty, first one wins
				best_cls = 4;
				for (int i = 0; i < cap; i++) begin
					cls = 2 * ref_bit[i] + dirty_bit[i];
					if (cls < best_cls) begin
						best_cls = cls;
						slot = i;
					end
				end
			end else begin
				// oldest access time, first one wins
				oldest = last_use[0];
				for (int i = 1; i < cap; i++) begin
					if (last_use[i] < oldest) begin
						oldest = last_use[i];
						slot = i;
					end
				end
			end
			resident_page[slot] = page;
			ref_bit[slot] = 1'b1;
			dirty_bit[slot] = 1'b0;
			last_use[slot] = now_tick;
		end
		// advance time, then age the referenced bits
		now_tick++;
		live = (filled_count < cap) ? filled_count : cap;
		for (int i = 0; i < live; i++) begin
			if (ref_bit[i] && TIME_W'(now_tick - last_use[i]) >= cur_age)
				ref_bit[i] = 1'b0;
		end
		r.hit = found;
		r.frame = FRAME_W'(slot);
		r.fault_total = fault_count;
		r.write_fault_total = write_fault_count;
		return r;
	endfunction

	// Offer one access in bursts with random gaps; predict it on transfer
	task automatic send_access(logic [ADDR_W-1:0] addr, logic wr);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		s_tuser <= wr;
		do
			@(posedge clk);
		while (!s_tready);
		awaited_outcomes.push_back(predict_access(addr, wr));
	endtask

	// Drop valid and hold until every result is back
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_POLICY:    cur_policy = val[CFG_POLICY_W-1:0];
			REG_PAGE_SIZE: cur_page_kb = val[CFG_PSIZE_W-1:0];
			REG_FRAMES:    cur_frames = val[CFG_FRAMES_W-1:0];
			REG_AGE_LIMIT: cur_age = val[CFG_AGE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [CFG_POLICY_W-1:0] pol, logic [CFG_PSIZE_W-1:0] kb,
			logic [CFG_FRAMES_W-1:0] frames, logic [CFG_AGE_W-1:0] age);
		wait_idle();
		write_reg(REG_POLICY, CFG_DATA_W'(pol));
		write_reg(REG_PAGE_SIZE, CFG_DATA_W'(kb));
		write_reg(REG_FRAMES, CFG_DATA_W'(frames));
		write_reg(REG_AGE_LIMIT, CFG_DATA_W'(age));
	endtask

	// Fill the working set with random pages, sometimes the extreme ones
	task automatic build_pool(int unsigned n);
		page_pool.delete();
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       page_pool.push_back('0);
				1:       page_pool.push_back('1);
				default: page_pool.push_back(PAGE_W'($urandom));
			endcase
		end
	endtask

	// Mostly working-set accesses with random offsets, the rest random noise
	task automatic run_accesses(int unsigned n);
		logic [ADDR_W-1:0] addr;
		int unsigned sh;
		for (int k = 0; k < n; k++) begin
			sh = page_shift(cur_page_kb);
			if ($urandom_range(0, 99) < NOISE_PCT) begin
				addr = $urandom;
			end else begin
				addr = ADDR_W'(page_pool[$urandom_range(0, page_pool.size() - 1)]) << sh;
				addr = addr | ($urandom & ((32'd1 << sh) - 1));
			end
			send_access(addr, 1'($urandom_range(0, 1)));
		end
	endtask

	// Reset defaults: field extremes, hits with read and write, free-frame fill, aging
	task automatic test_reset_defaults();
		send_access(32'h0000_0000, 1'b0);
		send_access(32'hFFFF_FFFF, 1'b1);
		send_access(32'h0000_1FFF, 1'b0);
		send_access(32'hFFFF_E000, 1'b1);
		send_access(32'h0000_2000, 1'b1);
		send_access(32'h8000_0000, 1'b0);
		send_access(32'h7FFF_FFFF, 1'b1);
		for (int k = 3; k < 9; k++)
			send_access(32'(k) << 13, 1'(k));
		send_access(32'h0000_0ABC, 1'b1);
		send_access(32'hAAAA_AAAA, 1'b0);
		send_access(32'h5555_5555, 1'b1);
	endtask

	task automatic test_lru_eviction();
		apply_settings(POLICY_LRU, 5'd8, 10'd4, 8'd5);
		build_pool(6);
		run_accesses(80);
	endtask

	task automatic test_nru_classes();
		apply_settings(POLICY_NRU, 5'd16, 10'd8, 8'd3);
		build_pool(11);
		run_accesses(80);
	endtask

	// Sizes below 8 KB clamp, sizes of 16 KB and up share the larger shift
	task automatic test_page_size_range();
		logic [CFG_PSIZE_W-1:0] sizes [6];
		sizes = '{5'd0, 5'd7, 5'd9, 5'd15, 5'd16, 5'd31};
		foreach (sizes[j]) begin
			apply_settings((j % 2 == 0) ? POLICY_LRU : POLICY_NRU, sizes[j], 10'd6, 8'd4);
			build_pool(8);
			run_accesses(12);
		end
	endtask

	// Frames above a lowered capacity are skipped, then seen again once raised
	task automatic test_capacity_lowered();
		apply_settings(POLICY_LRU, 5'd8, 10'd24, 8'd6);
		build_pool(30);
		run_accesses(60);
		apply_settings(POLICY_NRU, 5'd8, 10'd3, 8'd6);
		run_accesses(30);
		apply_settings(POLICY_LRU, 5'd8, 10'd24, 8'd6);
		run_accesses(30);
	endtask

	task automatic test_age_limit_extremes();
		apply_settings(POLICY_NRU, 5'd12, 10'd8, 8'd0);
		build_pool(12);
		run_accesses(40);
		apply_settings(POLICY_NRU, 5'd12, 10'd8, 8'd255);
		run_accesses(40);
	endtask

	// Zero acts as one frame, values above the depth act as the depth
	task automatic test_capacity_limits();
		apply_settings(POLICY_NRU, 5'd8, 10'd0, 8'd1);
		build_pool(3);
		run_accesses(30);
		apply_settings(POLICY_LRU, 5'd8, 10'd1, 8'd2);
		build_pool(2);
		run_accesses(20);
		apply_settings(POLICY_LRU, 5'd16, 10'd1023, 8'd5);
		build_pool(40);
		run_accesses(30);
		apply_settings(POLICY_NRU, 5'd16, 10'd512, 8'd7);
		run_accesses(20);
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_POLICY;
		cfg_data = '0;
		filled_count = 0;
		now_tick = '0;
		fault_count = '0;
		write_fault_count = '0;
		cur_policy = RST_POLICY;
		cur_page_kb = RST_PAGE_SIZE;
		cur_frames = RST_FRAMES;
		cur_age = RST_AGE_LIMIT;
		mismatches = 0;
		results_seen = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_lru_eviction();
		test_nru_classes();
		test_page_size_range();
		test_capacity_lowered();
		test_age_limit_extremes();
		test_capacity_limits();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("page_frame_replacement_lru_nru test passed");
		else
			$display("page_frame_replacement_lru_nru test failed");
		$finish;
	end

	// Receiver stalls: steady, sparse random, or runs of ready and stall
	initial begin
		rx_mode_e mode;
		int unsigned mode_left;
		int unsigned run_left;
		bit run_ready;
		mode = RX_STEADY;
		mode_left = 0;
		run_left = 0;
		run_ready = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 2));
				mode_left = $urandom_range(100, 400);
			end
			mode_left--;
			case (mode)
				RX_STEADY: m_tready <= 1'b1;
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (run_left == 0) begin
						run_ready = !run_ready;
						run_left = run_ready ? $urandom_range(1, 20) : $urandom_range(1, 25);
					end
					run_left--;
					m_tready <= run_ready;
				end
			endcase
		end
	end

	task automatic note_mismatch(string what, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %0h, got %0h", results_seen, what, want, got);
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		access_outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (awaited_outcomes.size() == 0) begin
				note_mismatch("unexpected result, frame", '0, COUNT_W'(m_tdata[8:0]));
			end else begin
				want = awaited_outcomes.pop_front();
				if (m_tuser !== want.hit)
					note_mismatch("hit", COUNT_W'(want.hit), COUNT_W'(m_tuser));
				if (m_tdata[8:0] !== want.frame)
					note_mismatch("frame", COUNT_W'(want.frame), COUNT_W'(m_tdata[8:0]));
				if (m_tdata[40:9] !== want.fault_total)
					note_mismatch("fault_total", want.fault_total, m_tdata[40:9]);
				if (m_tdata[72:41] !== want.write_fault_total)
					note_mismatch("write_fault_total", want.write_fault_total, m_tdata[72:41]);
			end
		end
	end

	// End the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("page_frame_replacement_lru_nru test failed");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
rtl/pfr_pkg.sv
rtl/pfr_scan.sv
rtl/page_frame_replacement_lru_nru.sv
verif/page_frame_replacement_lru_nru_tb.sv
